// File: rtl/pn_pkg.sv
// ----------------------------------------------------------------------------
// Path normalizer package
// Shared constants, character codes, command codes and the result beat type.
// ----------------------------------------------------------------------------
package pn_pkg;

  localparam int DEF_MAX_LEN   = 256;
  localparam int DEF_MAX_DEPTH = 64;

  localparam int CHAR_W   = 8;
  localparam int NEWLEN_W = 9;

  typedef logic [CHAR_W-1:0]   char_t;
  typedef logic [NEWLEN_W-1:0] newlen_t;

  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_SLASH = 8'h2F;
  localparam char_t CH_DOT   = 8'h2E;

  localparam logic CMD_APPEND  = 1'b0;
  localparam logic CMD_SET_LEN = 1'b1;

  // Result queue geometry: one input beat makes at most RES_SLOTS results.
  localparam int RES_SLOTS  = 3;
  localparam int RES_DEPTH  = 8;
  localparam int RES_PTR_W  = $clog2(RES_DEPTH);
  localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    logic    cmd_kind;
    char_t   out_byte;
    newlen_t new_length;
    logic    last_of_run;
    logic    path_end;
    logic    overflow;
  } res_t;

  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP
  } stk_op_t;

endpackage

// File: rtl/pn_path_if.sv
// ----------------------------------------------------------------------------
// Path character channel
// Carries one path character per beat; a zero character ends the path.
// ----------------------------------------------------------------------------
interface pn_path_if;
  import pn_pkg::*;

  logic  valid;
  logic  ready;
  char_t ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

// File: rtl/pn_cmd_if.sv
// ----------------------------------------------------------------------------
// Edit command channel
// Carries one buffer edit command per beat: append a byte or set the length.
// ----------------------------------------------------------------------------
interface pn_cmd_if;
  import pn_pkg::*;

  logic    valid;
  logic    ready;
  logic    cmd_kind;
  char_t   out_byte;
  newlen_t new_length;
  logic    last_of_run;
  logic    path_end;
  logic    overflow;

  modport source (
    output valid, output cmd_kind, output out_byte, output new_length,
    output last_of_run, output path_end, output overflow, input ready
  );
  modport sink (
    input valid, input cmd_kind, input out_byte, input new_length,
    input last_of_run, input path_end, input overflow, output ready
  );
endinterface

// File: rtl/pn_cell.sv
// ----------------------------------------------------------------------------
// Segment stack cell
// One entry of the shifting segment stack; takes its left neighbor on a push
// and its right neighbor on a pop.
// ----------------------------------------------------------------------------
module pn_cell #(
  parameter int LEN_W = 9
) (
  input  logic             clk,
  input  pn_pkg::stk_op_t  op,
  input  logic [LEN_W-1:0] prev_val,
  input  logic [LEN_W-1:0] next_val,
  output logic [LEN_W-1:0] value
);
  import pn_pkg::*;

  always_ff @(posedge clk) begin
    unique case (op)
      STK_PUSH: value <= prev_val;
      STK_POP:  value <= next_val;
      default:  value <= value;
    endcase
  end

endmodule

// File: rtl/pn_res_fifo.sv
// ----------------------------------------------------------------------------
// Result queue
// Takes up to three result beats per cycle and hands out one per cycle while the reader is ready.
// ----------------------------------------------------------------------------
module pn_res_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  pn_pkg::res_t [2:0]     wr_data,
  input  logic [1:0]             wr_count,
  output logic                   space_ok,
  output logic                   rd_valid,
  input  logic                   rd_ready,
  output pn_pkg::res_t           rd_data
);
  import pn_pkg::*;

  res_t                 mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_PTR_W-1:0] rd_ptr;
  logic [RES_CNT_W-1:0] count;
  logic                 rd_take;

  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign rd_take  = rd_valid && rd_ready;
  assign space_ok = (count <= RES_CNT_W'(RES_DEPTH - RES_SLOTS));

  always_ff @(posedge clk) begin
    for (int k = 0; k < RES_SLOTS; k++) begin
      if (2'(k) < wr_count) begin
        mem[wr_ptr + RES_PTR_W'(k)] <= wr_data[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_W'(wr_count);
      rd_ptr <= rd_ptr + RES_PTR_W'(rd_take);
      count  <= count + RES_CNT_W'(wr_count) - RES_CNT_W'(rd_take);
    end
  end

endmodule

// File: rtl/path_normalizer_top.sv
// ----------------------------------------------------------------------------
// Path normalizer
// Streams a path one character per beat and emits buffer edit commands that
// leave the canonical path in a downstream buffer.
//
//   Channel  Direction  Payload
//   path     in         ch
//   cmd      out        cmd_kind, out_byte, new_length, last_of_run,
//                       path_end, overflow
//
// A character is taken in every cycle while the result queue has room for
// three beats; its zero to three results enter the queue together and leave
// it one per cycle while cmd is ready, behind any results already queued.
// Segment starts live in a row of stack cells that shift on push and pop.
// The path channel stalls only when the result queue is nearly full.
// Synchronous reset clears all path state; the stack cells are not reset.
// ----------------------------------------------------------------------------
module path_normalizer_top #(
  parameter int MAX_LEN   = pn_pkg::DEF_MAX_LEN,
  parameter int MAX_DEPTH = pn_pkg::DEF_MAX_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  pn_path_if.sink  path,
  pn_cmd_if.source cmd
);
  import pn_pkg::*;

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int CNT_W = $clog2(MAX_DEPTH + 1);

  logic [LEN_W-1:0] out_length;
  logic [CNT_W-1:0] seg_count;
  logic             absolute_flag;
  logic [1:0]       pending_dots;
  logic             in_plain_segment;
  logic             at_path_start;
  logic             overflow_flag;

  logic             absolute_next;
  logic [1:0]       pending_next;
  logic             plain_next;
  logic             start_next;

  logic             accept;
  logic             space_ok;
  char_t            ch;
  logic [1:0]       n_app;
  char_t            app_byte [RES_SLOTS];
  logic             has_len;
  logic             path_done;
  logic             do_pop;
  logic             do_push;
  logic             stack_ovf;
  logic             slash_last;
  logic             use_top;

  logic [LEN_W-1:0] top_start;
  logic [LEN_W-1:0] base_len;
  logic [LEN_W-1:0] room;
  logic             app_ovf;
  logic [1:0]       n_ok;
  logic [LEN_W-1:0] len_after;
  logic             len_dec;
  logic [LEN_W-1:0] len_cmd;
  logic             ovf_after;
  logic [1:0]       n_wr;
  res_t [2:0]       slot;
  res_t             head;
  stk_op_t          stk_op;

  logic [LEN_W-1:0] cell_val  [MAX_DEPTH];
  logic [LEN_W-1:0] cell_prev [MAX_DEPTH];
  logic [LEN_W-1:0] cell_next [MAX_DEPTH];

  assign ch         = path.ch;
  assign path.ready = space_ok;
  assign accept     = path.valid && space_ok;
  assign top_start  = cell_val[0];

  always_comb begin
    n_app         = 2'd0;
    for (int k = 0; k < RES_SLOTS; k++) begin
      app_byte[k] = ch;
    end
    has_len       = 1'b0;
    path_done     = 1'b0;
    do_pop        = 1'b0;
    do_push       = 1'b0;
    stack_ovf     = 1'b0;
    slash_last    = 1'b0;
    use_top       = 1'b0;
    absolute_next = absolute_flag;
    pending_next  = pending_dots;
    plain_next    = in_plain_segment;
    start_next    = at_path_start;

    if (ch == CH_NUL) begin
      has_len   = 1'b1;
      path_done = 1'b1;
      if (!overflow_flag) begin
        if (in_plain_segment) begin
          slash_last = 1'b0;
        end else if (pending_dots == 2'd2 && seg_count != '0) begin
          do_pop     = 1'b1;
          use_top    = 1'b1;
          slash_last = (top_start != '0);
        end else if (pending_dots == 2'd2 && !absolute_flag) begin
          n_app       = 2'd2;
          app_byte[0] = CH_DOT;
          app_byte[1] = CH_DOT;
        end else begin
          slash_last = (out_length != '0);
        end
      end
    end else if (!overflow_flag) begin
      start_next = 1'b0;
      if (at_path_start && ch == CH_SLASH) begin
        absolute_next = 1'b1;
        n_app         = 2'd1;
      end else if (ch == CH_SLASH) begin
        if (in_plain_segment) begin
          n_app      = 2'd1;
          plain_next = 1'b0;
        end else if (pending_dots == 2'd2) begin
          pending_next = 2'd0;
          if (seg_count != '0) begin
            do_pop  = 1'b1;
            use_top = 1'b1;
            has_len = 1'b1;
          end else if (!absolute_flag) begin
            n_app       = 2'd3;
            app_byte[0] = CH_DOT;
            app_byte[1] = CH_DOT;
            app_byte[2] = CH_SLASH;
          end
        end else begin
          pending_next = 2'd0;
        end
      end else if (ch == CH_DOT && !in_plain_segment && pending_dots < 2'd2) begin
        pending_next = pending_dots + 2'd1;
      end else if (in_plain_segment) begin
        n_app = 2'd1;
      end else if (seg_count >= CNT_W'(MAX_DEPTH)) begin
        stack_ovf = 1'b1;
      end else begin
        do_push      = 1'b1;
        plain_next   = 1'b1;
        pending_next = 2'd0;
        if (pending_dots == 2'd1) begin
          n_app       = 2'd2;
          app_byte[0] = CH_DOT;
        end else if (pending_dots == 2'd2) begin
          n_app       = 2'd3;
          app_byte[0] = CH_DOT;
          app_byte[1] = CH_DOT;
        end else begin
          n_app = 2'd1;
        end
      end
    end
  end

  always_comb begin
    base_len  = use_top ? top_start : out_length;
    room      = LEN_W'(MAX_LEN) - base_len;
    app_ovf   = (LEN_W'(n_app) > room);
    n_ok      = app_ovf ? room[1:0] : n_app;
    len_after = base_len + LEN_W'(n_ok);
    ovf_after = overflow_flag || app_ovf || stack_ovf;
    len_dec   = !ovf_after && slash_last && (len_after > LEN_W'(1));
    len_cmd   = len_after - LEN_W'(len_dec);
    n_wr      = n_ok + {1'b0, has_len};
  end

  always_comb begin
    for (int k = 0; k < RES_SLOTS; k++) begin
      if (2'(k) < n_ok) begin
        slot[k].cmd_kind   = CMD_APPEND;
        slot[k].out_byte   = app_byte[k];
        slot[k].new_length = newlen_t'(base_len + LEN_W'(k + 1));
        slot[k].path_end   = 1'b0;
        slot[k].overflow   = 1'b0;
      end else begin
        slot[k].cmd_kind   = CMD_SET_LEN;
        slot[k].out_byte   = CH_NUL;
        slot[k].new_length = newlen_t'(len_cmd);
        slot[k].path_end   = path_done;
        slot[k].overflow   = ovf_after;
      end
      slot[k].last_of_run  = (2'(k) == n_wr - 2'd1);
    end
  end

  always_comb begin
    if (accept && do_push) begin
      stk_op = STK_PUSH;
    end else if (accept && do_pop) begin
      stk_op = STK_POP;
    end else begin
      stk_op = STK_HOLD;
    end
  end

  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_prev[i] = out_length;
    end else begin : g_body
      assign cell_prev[i] = cell_val[i-1];
    end
    if (i == MAX_DEPTH - 1) begin : g_tail
      assign cell_next[i] = cell_val[i];
    end else begin : g_link
      assign cell_next[i] = cell_val[i+1];
    end
    pn_cell #(
      .LEN_W (LEN_W)
    ) u_cell (
      .clk      (clk),
      .op       (stk_op),
      .prev_val (cell_prev[i]),
      .next_val (cell_next[i]),
      .value    (cell_val[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_length       <= '0;
      seg_count        <= '0;
      absolute_flag    <= 1'b0;
      pending_dots     <= 2'd0;
      in_plain_segment <= 1'b0;
      at_path_start    <= 1'b1;
      overflow_flag    <= 1'b0;
    end else if (accept) begin
      if (path_done) begin
        out_length       <= '0;
        seg_count        <= '0;
        absolute_flag    <= 1'b0;
        pending_dots     <= 2'd0;
        in_plain_segment <= 1'b0;
        at_path_start    <= 1'b1;
        overflow_flag    <= 1'b0;
      end else begin
        out_length       <= len_after;
        seg_count        <= seg_count + CNT_W'(do_push) - CNT_W'(do_pop);
        absolute_flag    <= absolute_next;
        pending_dots     <= pending_next;
        in_plain_segment <= plain_next;
        at_path_start    <= start_next;
        overflow_flag    <= ovf_after;
      end
    end
  end

  pn_res_fifo u_res_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (slot),
    .wr_count (accept ? n_wr : 2'd0),
    .space_ok (space_ok),
    .rd_valid (cmd.valid),
    .rd_ready (cmd.ready),
    .rd_data  (head)
  );

  assign cmd.cmd_kind    = head.cmd_kind;
  assign cmd.out_byte    = head.out_byte;
  assign cmd.new_length  = head.new_length;
  assign cmd.last_of_run = head.last_of_run;
  assign cmd.path_end    = head.path_end;
  assign cmd.overflow    = head.overflow;

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    seg_count <= CNT_W'(MAX_DEPTH))
    else $error("Segment stack count exceeds its depth.");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    out_length <= LEN_W'(MAX_LEN))
    else $error("Buffer length exceeds its limit.");

  a_plain_no_dots: assert property (@(posedge clk) disable iff (rst)
    in_plain_segment |-> pending_dots == 2'd0)
    else $error("Dots are held back inside a plain segment.");

  a_path_clear: assert property (@(posedge clk) disable iff (rst)
    accept && path_done |=> at_path_start && seg_count == '0 && !overflow_flag)
    else $error("Path state is not cleared after a terminator beat.");
`endif

endmodule
